### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked, with or without reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/dcs_pkg.sv
// ----------------------------------------------------------------------------
// dcs_pkg
// Types, stage counts and step functions of the distance constraint solver.
// ----------------------------------------------------------------------------
package dcs_pkg;

  localparam int FRONT_STAGES = 3;
  localparam int SQRT_STEPS   = 33;
  localparam int WDIV_STEPS   = 16;
  localparam int UDIV_STEPS   = 17;
  localparam int BACK_STAGES  = 5;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic [30:0]        mass_a;
    logic [30:0]        mass_b;
    logic [31:0]        rest_length;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_a_x;
    logic signed [31:0] new_a_y;
    logic signed [31:0] new_b_x;
    logic signed [31:0] new_b_y;
    logic               degenerate;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
  } pos_t;

  typedef struct packed {
    pos_t        pos;
    logic        neg_x;
    logic        neg_y;
    logic [31:0] adx;
    logic [31:0] ady;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [31:0] total;
    logic [31:0] rest;
    logic [63:0] sq_x;
    logic [63:0] sq_y;
    logic [64:0] rad;
  } fr_t;

  typedef struct packed {
    logic [65:0] rem;
    logic [32:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [49:0] rem;
    logic        qbit;
  } div_st_t;

  typedef struct packed {
    pos_t                  pos;
    logic                  neg_x;
    logic                  neg_y;
    logic [31:0]           adx;
    logic [31:0]           ady;
    logic [31:0]           rest;
    logic [31:0]           total;
    sqrt_st_t              sr;
    logic [49:0]           wrem_a;
    logic [49:0]           wrem_b;
    logic [WDIV_STEPS-1:0] wa;
    logic [WDIV_STEPS-1:0] wb;
  } sq_t;

  typedef struct packed {
    pos_t                  pos;
    logic                  neg_x;
    logic                  neg_y;
    logic                  deg;
    logic signed [34:0]    err;
    logic [32:0]           len;
    logic [WDIV_STEPS-1:0] wa;
    logic [WDIV_STEPS-1:0] wb;
    logic [49:0]           urem_x;
    logic [49:0]           urem_y;
    logic [UDIV_STEPS-1:0] ux_m;
    logic [UDIV_STEPS-1:0] uy_m;
    logic signed [17:0]    ux;
    logic signed [17:0]    uy;
  } ud_t;

  typedef struct packed {
    pos_t                  pos;
    logic                  deg;
    logic [WDIV_STEPS-1:0] wa;
    logic [WDIV_STEPS-1:0] wb;
    logic signed [34:0]    err;
    logic signed [52:0]    px;
    logic signed [52:0]    py;
    logic signed [34:0]    cx;
    logic signed [34:0]    cy;
    logic signed [51:0]    qax;
    logic signed [51:0]    qay;
    logic signed [51:0]    qbx;
    logic signed [51:0]    qby;
    logic signed [35:0]    dax;
    logic signed [35:0]    day;
    logic signed [35:0]    dbx;
    logic signed [35:0]    dby;
  } bk_t;

  // one restoring square root digit for root bit b
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s, int b);
    logic [65:0] trial;
    sqrt_st_t    r;
    trial = ({33'd0, s.root} << (b + 1)) | (66'd1 << (2 * b));
    r = s;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = s.root | (33'd1 << b);
    end
    return r;
  endfunction

  // one restoring division digit for quotient bit b
  function automatic div_st_t div_step(logic [49:0] rem, logic [32:0] den, int b);
    logic [49:0] trial;
    div_st_t     r;
    trial  = {17'd0, den} << b;
    r.rem  = rem;
    r.qbit = 1'b0;
    if (rem >= trial) begin
      r.rem  = rem - trial;
      r.qbit = 1'b1;
    end
    return r;
  endfunction

  // divide by 2^16, rounding toward zero
  function automatic logic signed [36:0] trunc_q16(logic signed [52:0] p);
    logic signed [52:0] s;
    s = p[52] ? p + 53'sd65535 : p;
    return $signed(s[52:16]);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

### rtl/dcs_front.sv
// ----------------------------------------------------------------------------
// dcs_front
// Separation vector, its magnitude per axis, squares and squared length.
// ----------------------------------------------------------------------------
module dcs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_hold,
  input  dcs_pkg::in_item_t up_data,
  output logic              dn_valid,
  input  logic              dn_hold,
  output dcs_pkg::fr_t      dn_data
);
  localparam int N = dcs_pkg::FRONT_STAGES;

  logic [N-1:0]      v_r;
  logic [N-1:0]      v_shift;
  logic [N:0]        hold;
  dcs_pkg::fr_t      d_r   [N];
  dcs_pkg::fr_t      d_nxt [N];
  logic signed [32:0] dx;
  logic signed [32:0] dy;

  assign hold[N] = dn_hold;
  for (genvar k = 0; k < N; k++) begin : g_hold
    assign hold[k] = v_r[k] & hold[k+1];
  end
  assign v_shift = {v_r[N-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (!hold[k]) v_r[k] <= v_shift[k];
      end
    end
  end

  always_comb begin
    dx = $signed({up_data.a_x[31], up_data.a_x}) - $signed({up_data.b_x[31], up_data.b_x});
    dy = $signed({up_data.a_y[31], up_data.a_y}) - $signed({up_data.b_y[31], up_data.b_y});
    d_nxt[0]        = '0;
    d_nxt[0].pos.ax = up_data.a_x;
    d_nxt[0].pos.ay = up_data.a_y;
    d_nxt[0].pos.bx = up_data.b_x;
    d_nxt[0].pos.by = up_data.b_y;
    d_nxt[0].neg_x  = dx[32];
    d_nxt[0].neg_y  = dy[32];
    d_nxt[0].adx    = dx[32] ? 32'(-dx) : 32'(dx);
    d_nxt[0].ady    = dy[32] ? 32'(-dy) : 32'(dy);
    d_nxt[0].ma     = up_data.mass_a;
    d_nxt[0].mb     = up_data.mass_b;
    d_nxt[0].total  = {1'b0, up_data.mass_a} + {1'b0, up_data.mass_b};
    d_nxt[0].rest   = up_data.rest_length;

    d_nxt[1]      = d_r[0];
    d_nxt[1].sq_x = {32'd0, d_r[0].adx} * {32'd0, d_r[0].adx};
    d_nxt[1].sq_y = {32'd0, d_r[0].ady} * {32'd0, d_r[0].ady};

    d_nxt[2]     = d_r[1];
    d_nxt[2].rad = {1'b0, d_r[1].sq_x} + {1'b0, d_r[1].sq_y};
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (!hold[k]) d_r[k] <= d_nxt[k];
    end
  end

  assign up_hold  = hold[0];
  assign dn_valid = v_r[N-1];
  assign dn_data  = d_r[N-1];

endmodule

### rtl/dcs_sqrt.sv
// ----------------------------------------------------------------------------
// dcs_sqrt
// Pipelined integer square root, one root bit per stage; the mass weights
// are divided out in the first stages alongside.
// ----------------------------------------------------------------------------
module dcs_sqrt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_hold,
  input  dcs_pkg::fr_t up_data,
  output logic         dn_valid,
  input  logic         dn_hold,
  output dcs_pkg::sq_t dn_data
);
  localparam int N = dcs_pkg::SQRT_STEPS;
  localparam int W = dcs_pkg::WDIV_STEPS;

  logic [N-1:0] v_r;
  logic [N-1:0] v_shift;
  logic [N:0]   hold;
  dcs_pkg::sq_t d_r   [N];
  dcs_pkg::sq_t d_nxt [N];

  assign hold[N] = dn_hold;
  assign v_shift = {v_r[N-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (!hold[k]) v_r[k] <= v_shift[k];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    dcs_pkg::sq_t      src;
    dcs_pkg::sqrt_st_t sr_nxt;
    logic [49:0]       wra_nxt;
    logic [49:0]       wrb_nxt;
    logic [W-1:0]      wa_nxt;
    logic [W-1:0]      wb_nxt;

    assign hold[k] = v_r[k] & hold[k+1];

    if (k == 0) begin : g_load
      always_comb begin
        src         = '0;
        src.pos     = up_data.pos;
        src.neg_x   = up_data.neg_x;
        src.neg_y   = up_data.neg_y;
        src.adx     = up_data.adx;
        src.ady     = up_data.ady;
        src.rest    = up_data.rest;
        src.total   = up_data.total;
        src.sr.rem  = {1'b0, up_data.rad};
        src.wrem_a  = {4'd0, up_data.ma, 15'd0};
        src.wrem_b  = {4'd0, up_data.mb, 15'd0};
      end
    end else begin : g_chain
      assign src = d_r[k-1];
    end

    assign sr_nxt = dcs_pkg::sqrt_step(src.sr, N - 1 - k);

    if (k < W) begin : g_wdiv
      dcs_pkg::div_st_t qa;
      dcs_pkg::div_st_t qb;
      assign qa      = dcs_pkg::div_step(src.wrem_a, {1'b0, src.total}, W - 1 - k);
      assign qb      = dcs_pkg::div_step(src.wrem_b, {1'b0, src.total}, W - 1 - k);
      assign wra_nxt = qa.rem;
      assign wrb_nxt = qb.rem;
      always_comb begin
        wa_nxt = src.wa;
        wb_nxt = src.wb;
        wa_nxt[W-1-k] = qa.qbit;
        wb_nxt[W-1-k] = qb.qbit;
      end
    end else begin : g_wpass
      assign wra_nxt = src.wrem_a;
      assign wrb_nxt = src.wrem_b;
      assign wa_nxt  = src.wa;
      assign wb_nxt  = src.wb;
    end

    always_comb begin
      d_nxt[k]        = src;
      d_nxt[k].sr     = sr_nxt;
      d_nxt[k].wrem_a = wra_nxt;
      d_nxt[k].wrem_b = wrb_nxt;
      d_nxt[k].wa     = wa_nxt;
      d_nxt[k].wb     = wb_nxt;
    end

    always_ff @(posedge clk) begin
      if (!hold[k]) d_r[k] <= d_nxt[k];
    end
  end

  assign up_hold  = hold[0];
  assign dn_valid = v_r[N-1];
  assign dn_data  = d_r[N-1];

endmodule

### rtl/dcs_udiv.sv
// ----------------------------------------------------------------------------
// dcs_udiv
// Unit separation vector: |d| * 2^16 / length, one quotient bit per stage,
// then the sign is put back. Length error and degenerate flag ride along.
// ----------------------------------------------------------------------------
module dcs_udiv (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_hold,
  input  dcs_pkg::sq_t up_data,
  output logic         dn_valid,
  input  logic         dn_hold,
  output dcs_pkg::ud_t dn_data
);
  localparam int Q = dcs_pkg::UDIV_STEPS;
  localparam int N = Q + 1;

  logic [N-1:0] v_r;
  logic [N-1:0] v_shift;
  logic [N:0]   hold;
  dcs_pkg::ud_t d_r   [N];
  dcs_pkg::ud_t d_nxt [N];

  assign hold[N] = dn_hold;
  assign v_shift = {v_r[N-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (!hold[k]) v_r[k] <= v_shift[k];
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    dcs_pkg::ud_t src;

    assign hold[k] = v_r[k] & hold[k+1];

    if (k == 0) begin : g_load
      always_comb begin
        src        = '0;
        src.pos    = up_data.pos;
        src.neg_x  = up_data.neg_x;
        src.neg_y  = up_data.neg_y;
        src.len    = up_data.sr.root;
        src.deg    = (up_data.sr.root == '0) || (up_data.total == '0);
        src.err    = $signed({3'd0, up_data.rest}) - $signed({2'd0, up_data.sr.root});
        src.wa     = up_data.wa;
        src.wb     = up_data.wb;
        src.urem_x = {2'd0, up_data.adx, 16'd0};
        src.urem_y = {2'd0, up_data.ady, 16'd0};
      end
    end else begin : g_chain
      assign src = d_r[k-1];
    end

    if (k < Q) begin : g_div
      dcs_pkg::div_st_t qx;
      dcs_pkg::div_st_t qy;
      assign qx = dcs_pkg::div_step(src.urem_x, src.len, Q - 1 - k);
      assign qy = dcs_pkg::div_step(src.urem_y, src.len, Q - 1 - k);
      always_comb begin
        d_nxt[k]             = src;
        d_nxt[k].urem_x      = qx.rem;
        d_nxt[k].urem_y      = qy.rem;
        d_nxt[k].ux_m[Q-1-k] = qx.qbit;
        d_nxt[k].uy_m[Q-1-k] = qy.qbit;
      end
    end else begin : g_sign
      always_comb begin
        d_nxt[k]    = src;
        d_nxt[k].ux = src.neg_x ? -$signed({1'b0, src.ux_m}) : $signed({1'b0, src.ux_m});
        d_nxt[k].uy = src.neg_y ? -$signed({1'b0, src.uy_m}) : $signed({1'b0, src.uy_m});
      end
    end

    always_ff @(posedge clk) begin
      if (!hold[k]) d_r[k] <= d_nxt[k];
    end
  end

  assign up_hold  = hold[0];
  assign dn_valid = v_r[N-1];
  assign dn_data  = d_r[N-1];

endmodule

### rtl/dcs_back.sv
// ----------------------------------------------------------------------------
// dcs_back
// Correction vector, mass weighting, saturating position update (skipped
// for degenerate items) and the output register.
// ----------------------------------------------------------------------------
module dcs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_hold,
  input  dcs_pkg::ud_t       up_data,
  output logic               dn_valid,
  input  logic               dn_hold,
  output dcs_pkg::out_item_t dn_data
);
  localparam int N = dcs_pkg::BACK_STAGES;

  logic [N-1:0]        v_r;
  logic [N-1:0]        v_shift;
  logic [N:0]          hold;
  dcs_pkg::bk_t        d_r   [N-1];
  dcs_pkg::bk_t        d_nxt [N-1];
  dcs_pkg::out_item_t  out_r;
  dcs_pkg::out_item_t  out_nxt;
  logic signed [36:0]  tcx, tcy;
  logic signed [36:0]  tax, tay, tbx, tby;

  assign hold[N] = dn_hold;
  for (genvar k = 0; k < N; k++) begin : g_hold
    assign hold[k] = v_r[k] & hold[k+1];
  end
  assign v_shift = {v_r[N-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (!hold[k]) v_r[k] <= v_shift[k];
      end
    end
  end

  always_comb begin
    d_nxt[0]     = '0;
    d_nxt[0].pos = up_data.pos;
    d_nxt[0].deg = up_data.deg;
    d_nxt[0].wa  = up_data.wa;
    d_nxt[0].wb  = up_data.wb;
    d_nxt[0].err = up_data.err;
    d_nxt[0].px  = up_data.ux * up_data.err;
    d_nxt[0].py  = up_data.uy * up_data.err;

    tcx         = dcs_pkg::trunc_q16(d_r[0].px);
    tcy         = dcs_pkg::trunc_q16(d_r[0].py);
    d_nxt[1]    = d_r[0];
    d_nxt[1].cx = $signed(tcx[34:0]);
    d_nxt[1].cy = $signed(tcy[34:0]);

    d_nxt[2]     = d_r[1];
    d_nxt[2].qax = d_r[1].cx * $signed({1'b0, d_r[1].wa});
    d_nxt[2].qay = d_r[1].cy * $signed({1'b0, d_r[1].wa});
    d_nxt[2].qbx = d_r[1].cx * $signed({1'b0, d_r[1].wb});
    d_nxt[2].qby = d_r[1].cy * $signed({1'b0, d_r[1].wb});

    tax          = dcs_pkg::trunc_q16(53'(d_r[2].qax));
    tay          = dcs_pkg::trunc_q16(53'(d_r[2].qay));
    tbx          = dcs_pkg::trunc_q16(53'(d_r[2].qbx));
    tby          = dcs_pkg::trunc_q16(53'(d_r[2].qby));
    d_nxt[3]     = d_r[2];
    d_nxt[3].dax = $signed(tax[35:0]);
    d_nxt[3].day = $signed(tay[35:0]);
    d_nxt[3].dbx = $signed(tbx[35:0]);
    d_nxt[3].dby = $signed(tby[35:0]);

    out_nxt.degenerate = d_r[3].deg;
    if (d_r[3].deg) begin
      out_nxt.new_a_x = d_r[3].pos.ax;
      out_nxt.new_a_y = d_r[3].pos.ay;
      out_nxt.new_b_x = d_r[3].pos.bx;
      out_nxt.new_b_y = d_r[3].pos.by;
    end else begin
      out_nxt.new_a_x = dcs_pkg::sat32(38'(d_r[3].pos.ax) + 38'(d_r[3].dax));
      out_nxt.new_a_y = dcs_pkg::sat32(38'(d_r[3].pos.ay) + 38'(d_r[3].day));
      out_nxt.new_b_x = dcs_pkg::sat32(38'(d_r[3].pos.bx) - 38'(d_r[3].dbx));
      out_nxt.new_b_y = dcs_pkg::sat32(38'(d_r[3].pos.by) - 38'(d_r[3].dby));
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N - 1; k++) begin
      if (!hold[k]) d_r[k] <= d_nxt[k];
    end
    if (!hold[N-1]) out_r <= out_nxt;
  end

  assign up_hold  = hold[0];
  assign dn_valid = v_r[N-1];
  assign dn_data  = out_r;

endmodule

### rtl/distance_constraint_solver.sv
// ----------------------------------------------------------------------------
// distance_constraint_solver
// One relaxation step of a 2D stick constraint in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | in_valid, in_stall, in_data    | in
//  result  | out_valid, out_stall, out_data | out
//
//  One transaction per cycle sustained without stall; 3 front stages,
//  33 square root stages (one root bit each), 18 unit divide stages (one
//  quotient bit each plus sign), 5 correction stages ending in the output
//  register. Synchronous active-low reset clears only the valid bits.
//  A stall at the output holds full stages only; empty stages keep filling,
//  so in_stall rises only when every stage holds a transaction.
// ----------------------------------------------------------------------------
module distance_constraint_solver (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dcs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dcs_pkg::out_item_t out_data
);
  logic         fr_valid, fr_hold;
  dcs_pkg::fr_t fr_data;
  logic         sq_valid, sq_hold;
  dcs_pkg::sq_t sq_data;
  logic         ud_valid, ud_hold;
  dcs_pkg::ud_t ud_data;

  dcs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_hold  (in_stall),
    .up_data  (in_data),
    .dn_valid (fr_valid),
    .dn_hold  (fr_hold),
    .dn_data  (fr_data)
  );

  dcs_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fr_valid),
    .up_hold  (fr_hold),
    .up_data  (fr_data),
    .dn_valid (sq_valid),
    .dn_hold  (sq_hold),
    .dn_data  (sq_data)
  );

  dcs_udiv u_udiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sq_valid),
    .up_hold  (sq_hold),
    .up_data  (sq_data),
    .dn_valid (ud_valid),
    .dn_hold  (ud_hold),
    .dn_data  (ud_data)
  );

  dcs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ud_valid),
    .up_hold  (ud_hold),
    .up_data  (ud_data),
    .dn_valid (out_valid),
    .dn_hold  (out_stall),
    .dn_data  (out_data)
  );

endmodule

### rtl/dcs_checker.sv
// ----------------------------------------------------------------------------
// dcs_checker
// Port-level checks on the solver, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dcs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dcs_pkg::out_item_t out_data
);

  `ASSERT_CLK(a_out_valid_held, clk, rst_n, out_valid && out_stall |=> out_valid, "result transaction dropped under stall")
  `ASSERT_CLK(a_out_data_held, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "stalled result changed")
  `ASSERT_CLK(a_stall_only_full, clk, rst_n, in_stall |-> out_valid && out_stall, "input stalled while pipeline can move")
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind distance_constraint_solver dcs_checker u_checker (.*);
